### design/double_hash_table_defines.svh
// Assertion macros used by the dht_checker module
`ifndef DOUBLE_HASH_TABLE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_DEFINES_SVH

// implication checked on every edge outside reset
`define DHT_ASSERT(label, rst_n, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked on every edge, reset included
`define DHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dht_pkg.sv
package dht_pkg;

    localparam int KEY_W = 48;
    localparam int PAY_W = 32;
    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int SZ_W  = 11;
    localparam int DCNT_W = $clog2(KEY_W + 1);

    localparam logic [SZ_W-1:0] SIZE_RESET = SZ_W'(1021);
    localparam logic [SZ_W-1:0] SIZE_MIN   = SZ_W'(3);
    localparam logic [SZ_W-1:0] SIZE_MAX   = SZ_W'(DEPTH);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] SL_EMPTY = 2'd0;
    localparam logic [1:0] SL_USED  = 2'd1;
    localparam logic [1:0] SL_GONE  = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] slot_index;
        logic [PAY_W-1:0] payload_out;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [IDX_W-1:0] home;
        logic [IDX_W-1:0] step;
    } t_job;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_CHECK, B_OUT} t_bstate;

endpackage

### design/dht_front.sv
module dht_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_block,
    input  logic [dht_pkg::SZ_W-1:0]     i_size,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  dht_pkg::t_in_item            i_in_data,
    output logic                         o_job_valid,
    input  logic                         i_job_ready,
    output dht_pkg::t_job                o_job
);

    dht_pkg::t_fstate r_state, n_state;
    logic [dht_pkg::DCNT_W-1:0] r_cnt, n_cnt;
    logic [dht_pkg::KEY_W-1:0]  r_shift, n_shift;
    logic [dht_pkg::IDX_W-1:0]  r_rem1, n_rem1, r_rem2, n_rem2;
    dht_pkg::t_in_item          r_item, n_item;

    logic [dht_pkg::SZ_W-1:0] d1, d2, t1, t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dht_pkg::F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_shift <= n_shift;
        r_rem1  <= n_rem1;
        r_rem2  <= n_rem2;
        r_item  <= n_item;
    end

    // restoring division, one key bit per cycle, against S and S-1 at once
    always_comb begin
        d1 = i_size;
        d2 = i_size - dht_pkg::SZ_W'(1);
        t1 = {r_rem1, r_shift[dht_pkg::KEY_W-1]};
        t2 = {r_rem2, r_shift[dht_pkg::KEY_W-1]};
        n_state = r_state;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_rem1  = r_rem1;
        n_rem2  = r_rem2;
        n_item  = r_item;
        o_in_ready  = 1'b0;
        o_job_valid = 1'b0;
        case (r_state)
            dht_pkg::F_IDLE: begin
                o_in_ready = !i_block;
                if (i_in_valid && !i_block) begin
                    n_item  = i_in_data;
                    n_shift = i_in_data.key;
                    n_rem1  = '0;
                    n_rem2  = '0;
                    n_cnt   = '0;
                    n_state = dht_pkg::F_DIV;
                end
            end
            dht_pkg::F_DIV: begin
                n_shift = {r_shift[dht_pkg::KEY_W-2:0], 1'b0};
                n_rem1  = (t1 >= d1) ? dht_pkg::IDX_W'(t1 - d1) : t1[dht_pkg::IDX_W-1:0];
                n_rem2  = (t2 >= d2) ? dht_pkg::IDX_W'(t2 - d2) : t2[dht_pkg::IDX_W-1:0];
                n_cnt   = r_cnt + dht_pkg::DCNT_W'(1);
                if (r_cnt == dht_pkg::DCNT_W'(dht_pkg::KEY_W - 1)) begin
                    n_state = dht_pkg::F_PUSH;
                end
            end
            dht_pkg::F_PUSH: begin
                o_job_valid = 1'b1;
                if (i_job_ready) begin
                    n_state = dht_pkg::F_IDLE;
                end
            end
            default: n_state = dht_pkg::F_IDLE;
        endcase
    end

    assign o_job.opcode  = r_item.opcode;
    assign o_job.key     = r_item.key;
    assign o_job.payload = r_item.payload;
    assign o_job.home    = r_rem1;
    assign o_job.step    = r_rem2 + dht_pkg::IDX_W'(1);

endmodule

### design/dht_queue.sv
module dht_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dht_pkg::t_job i_data,
    output logic          o_not_full,
    input  logic          i_pop,
    output logic          o_not_empty,
    output dht_pkg::t_job o_data
);

    dht_pkg::t_job r_mem [2];
    logic          r_wptr, r_rptr;
    logic [1:0]    r_count;

    logic do_push, do_pop;

    assign o_not_full  = (r_count != 2'd2);
    assign o_not_empty = (r_count != 2'd0);
    assign do_push = i_push && o_not_full;
    assign do_pop  = i_pop && o_not_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wptr <= !r_wptr;
            if (do_pop)  r_rptr <= !r_rptr;
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
        if (do_push) r_mem[r_wptr] <= i_data;
    end

endmodule

### design/dht_back.sv
module dht_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [dht_pkg::SZ_W-1:0] i_size,
    output logic                     o_clearing,
    input  logic                     i_job_valid,
    output logic                     o_job_pop,
    input  dht_pkg::t_job            i_job,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output dht_pkg::t_out_item       o_out_data
);

    logic [dht_pkg::KEY_W-1:0] key_mem  [dht_pkg::DEPTH];
    logic [dht_pkg::PAY_W-1:0] pay_mem  [dht_pkg::DEPTH];
    logic [1:0]                stat_mem [dht_pkg::DEPTH];

    dht_pkg::t_bstate r_state, n_state;
    logic [dht_pkg::IDX_W-1:0] r_clr, n_clr;
    logic [1:0]                r_op, n_op;
    logic [dht_pkg::KEY_W-1:0] r_key, n_key;
    logic [dht_pkg::PAY_W-1:0] r_pay, n_pay;
    logic [dht_pkg::IDX_W-1:0] r_pos, n_pos, r_step, n_step;
    logic [dht_pkg::SZ_W-1:0]  r_n, n_n;
    dht_pkg::t_out_item        r_res, n_res, r_odata, n_odata;
    logic                      r_ovalid, n_ovalid;

    logic [dht_pkg::KEY_W-1:0] key_q;
    logic [dht_pkg::PAY_W-1:0] pay_q;
    logic [1:0]                stat_q;

    logic                      data_we, st_we;
    logic [dht_pkg::IDX_W-1:0] st_waddr;
    logic [1:0]                st_wdata;
    logic [dht_pkg::SZ_W-1:0]  pos_sum;
    logic                      last;

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            key_mem[r_pos] <= r_key;
            pay_mem[r_pos] <= r_pay;
        end
        if (st_we) stat_mem[st_waddr] <= st_wdata;
        key_q  <= key_mem[r_pos];
        pay_q  <= pay_mem[r_pos];
        stat_q <= stat_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dht_pkg::B_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
        r_op    <= n_op;
        r_key   <= n_key;
        r_pay   <= n_pay;
        r_pos   <= n_pos;
        r_step  <= n_step;
        r_n     <= n_n;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    always_comb begin
        pos_sum = {1'b0, r_pos} + {1'b0, r_step};
        last    = (r_n + dht_pkg::SZ_W'(1) == i_size);
        n_state  = r_state;
        n_clr    = r_clr;
        n_op     = r_op;
        n_key    = r_key;
        n_pay    = r_pay;
        n_pos    = r_pos;
        n_step   = r_step;
        n_n      = r_n;
        n_res    = r_res;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !i_out_ready;
        data_we  = 1'b0;
        st_we    = 1'b0;
        st_waddr = r_pos;
        st_wdata = dht_pkg::SL_USED;
        o_job_pop = 1'b0;
        case (r_state)
            dht_pkg::B_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = r_clr;
                st_wdata = dht_pkg::SL_EMPTY;
                n_clr    = r_clr + dht_pkg::IDX_W'(1);
                if (&r_clr) n_state = dht_pkg::B_IDLE;
            end
            dht_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_op   = i_job.opcode;
                    n_key  = i_job.key;
                    n_pay  = i_job.payload;
                    n_pos  = i_job.home;
                    n_step = i_job.step;
                    n_n    = '0;
                    n_res  = '{status: dht_pkg::ST_MISS, slot_index: '0, payload_out: '0};
                    n_state = (i_job.opcode == dht_pkg::OP_NONE) ? dht_pkg::B_OUT
                                                                 : dht_pkg::B_READ;
                end
            end
            dht_pkg::B_READ: n_state = dht_pkg::B_CHECK;
            dht_pkg::B_CHECK: begin
                n_state = dht_pkg::B_OUT;
                if (r_op == dht_pkg::OP_INSERT) begin
                    if (stat_q != dht_pkg::SL_USED) begin
                        data_we = 1'b1;
                        st_we   = 1'b1;
                        n_res   = '{status: dht_pkg::ST_OK, slot_index: r_pos, payload_out: '0};
                    end else if (last) begin
                        n_res.status = dht_pkg::ST_FULL;
                    end else begin
                        n_state = dht_pkg::B_READ;
                    end
                end else begin
                    if (stat_q == dht_pkg::SL_EMPTY) begin
                        n_res.status = dht_pkg::ST_MISS;
                    end else if (stat_q == dht_pkg::SL_USED && key_q == r_key) begin
                        n_res.status     = dht_pkg::ST_OK;
                        n_res.slot_index = r_pos;
                        if (r_op == dht_pkg::OP_SEARCH) begin
                            n_res.payload_out = pay_q;
                        end else begin
                            st_we    = 1'b1;
                            st_wdata = dht_pkg::SL_GONE;
                        end
                    end else if (!last) begin
                        n_state = dht_pkg::B_READ;
                    end
                end
                if (n_state == dht_pkg::B_READ) begin
                    n_n   = r_n + dht_pkg::SZ_W'(1);
                    n_pos = (pos_sum >= i_size) ? dht_pkg::IDX_W'(pos_sum - i_size)
                                                : pos_sum[dht_pkg::IDX_W-1:0];
                end
            end
            dht_pkg::B_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_state  = dht_pkg::B_IDLE;
                end
            end
            default: n_state = dht_pkg::B_IDLE;
        endcase
    end

    assign o_clearing  = (r_state == dht_pkg::B_CLEAR);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

### design/double_hash_table.sv
// Channel   Dir  Handshake                      Payload
// in        in   i_in_valid / o_in_ready        t_in_item  (opcode, key, payload)
// out       out  o_out_valid / i_out_ready      t_out_item (status, slot_index, payload_out)
// cfg       in   i_cfg_we                       table_size, 11 bits
//
// Front: bit-serial division over the 48 key bits (key mod S and key mod S-1), then a push to the queue.
// Back: each probe is a registered slot-memory read, then a check; the result goes out through a register.
// The front takes a new item only once the last is queued; probe-heavy items are paced by the back.
// After reset all 1024 slot states are swept to empty; o_in_ready is low then.
// Front and back stall on their own through a two-entry job queue.
module double_hash_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [dht_pkg::SZ_W-1:0] i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  dht_pkg::t_in_item        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output dht_pkg::t_out_item       o_out_data
);

    logic [dht_pkg::SZ_W-1:0] r_tsz;
    logic [dht_pkg::SZ_W-1:0] size;
    logic          clearing, job_valid, q_not_full, q_not_empty, q_pop;
    dht_pkg::t_job job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsz <= dht_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            r_tsz <= i_cfg_wdata;
        end
    end

    assign size = (r_tsz < dht_pkg::SIZE_MIN) ? dht_pkg::SIZE_MIN :
                  (r_tsz > dht_pkg::SIZE_MAX) ? dht_pkg::SIZE_MAX : r_tsz;

    dht_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_block     (clearing),
        .i_size      (size),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (job_valid),
        .i_job_ready (q_not_full),
        .o_job       (job_in)
    );

    dht_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (job_valid),
        .i_data      (job_in),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_data      (job_out)
    );

    dht_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (size),
        .o_clearing  (clearing),
        .i_job_valid (q_not_empty),
        .o_job_pop   (q_pop),
        .i_job       (job_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### design/dht_checker.sv
`include "double_hash_table_defines.svh"

module dht_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input dht_pkg::t_out_item       o_out_data
);

    // item waiting at the output holds until taken
    `DHT_ASSERT_NEXT(a_out_hold, i_rst_n && o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data), "output item changed while stalled")

    // a failed operation reports no slot and no data
    `DHT_ASSERT(a_fail_zero, i_rst_n, o_out_valid && o_out_data.status != dht_pkg::ST_OK,
        o_out_data.slot_index == '0 && o_out_data.payload_out == '0,
        "failed item carries slot or data")

    `DHT_ASSERT(a_status_code, i_rst_n, o_out_valid,
        o_out_data.status == dht_pkg::ST_OK || o_out_data.status == dht_pkg::ST_MISS ||
        o_out_data.status == dht_pkg::ST_FULL, "bad status code")

    // slot-state sweep starts right after reset, so no item is taken
    `DHT_ASSERT_NEXT(a_clear_block, !i_rst_n, !(i_in_valid && o_in_ready),
        "item taken during clear sweep")

endmodule

bind double_hash_table dht_checker u_dht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### verif/double_hash_table_checker.sv
`timescale 1ns / 100ps

module double_hash_table_checker
    import dht_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [SZ_W-1:0] i_cfg_wdata,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_errors,
    output int        o_pending
);

    logic [KEY_W-1:0] tbl_key [DEPTH];
    logic [PAY_W-1:0] tbl_pay [DEPTH];
    logic [1:0]       tbl_st  [DEPTH];
    logic [SZ_W-1:0]  size_reg;
    t_out_item        expected_q[$];

    assign o_pending = expected_q.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic int size_used();
        int s;
        s = int'(size_reg);
        if (s < 3) s = 3;
        if (s > DEPTH) s = DEPTH;
        return s;
    endfunction

    // walks the probe sequence and updates the table copy on insert and delete
    function automatic t_out_item hash_lookup(input t_in_item it);
        t_out_item r;
        longint unsigned k, pos, stp;
        int s, n, hit;
        s = size_used();
        k = it.key;
        pos = k % s;
        stp = 1 + k % (s - 1);
        hit = -1;
        r = '0;
        r.status = ST_MISS;
        if (it.opcode == OP_INSERT) begin
            r.status = ST_FULL;
            for (n = 0; n < s; n++) begin
                if (tbl_st[pos] != SL_USED) begin
                    tbl_key[pos] = it.key;
                    tbl_pay[pos] = it.payload;
                    tbl_st[pos] = SL_USED;
                    r.status = ST_OK;
                    r.slot_index = IDX_W'(pos);
                    break;
                end
                pos = (pos + stp) % s;
            end
        end else if (it.opcode == OP_SEARCH || it.opcode == OP_DELETE) begin
            for (n = 0; n < s; n++) begin
                if (tbl_st[pos] == SL_EMPTY) break;
                if (tbl_st[pos] == SL_USED && tbl_key[pos] == it.key) begin
                    hit = int'(pos);
                    break;
                end
                pos = (pos + stp) % s;
            end
            if (hit >= 0) begin
                r.status = ST_OK;
                r.slot_index = IDX_W'(hit);
                if (it.opcode == OP_SEARCH) r.payload_out = tbl_pay[hit];
                else tbl_st[hit] = SL_GONE;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            size_reg = SIZE_RESET;
            for (int i = 0; i < DEPTH; i++) tbl_st[i] = SL_EMPTY;
            expected_q.delete();
        end else begin
            if (i_cfg_we) size_reg = i_cfg_wdata;
            if (i_in_valid && i_in_ready) expected_q.push_back(hash_lookup(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    e = expected_q.pop_front();
                    if (i_out_data.status !== e.status)
                        report_mismatch("status", int'(i_out_data.status), int'(e.status));
                    if (i_out_data.slot_index !== e.slot_index)
                        report_mismatch("slot_index", int'(i_out_data.slot_index),
                                        int'(e.slot_index));
                    if (i_out_data.payload_out !== e.payload_out)
                        report_mismatch("payload_out", int'(i_out_data.payload_out),
                                        int'(e.payload_out));
                end
            end
        end
    end

    initial o_errors = 0;

endmodule

### verif/double_hash_table_tb.sv
`timescale 1ns / 100ps

module double_hash_table_tb;
    import dht_pkg::*;

    localparam int STALL_LIMIT = 60000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [SZ_W-1:0] i_cfg_wdata;
    logic            i_in_valid;
    logic            o_in_ready;
    t_in_item        i_in_data;
    logic            o_out_valid;
    logic            i_out_ready;
    t_out_item       o_out_data;
    int              errors;
    int              pending;
    int              idle_cycles;
    bit              hold_out;
    bit              sink_run;
    logic [KEY_W-1:0] key_pool[$];

    double_hash_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    double_hash_table_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAIL double_hash_table");
            $finish;
        end
    end

    // receiver: random stall per item, or a long hold when asked
    initial begin
        int w;
        i_out_ready = 0;
        wait (sink_run);
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                i_out_ready <= 0;
            end else begin
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                if (w != 0) begin
                    i_out_ready <= 0;
                    repeat (w) @(negedge i_clk);
                end
                i_out_ready <= 1;
                @(posedge i_clk);
                while (!o_out_valid) @(posedge i_clk);
            end
        end
    end

    // valid stays up across back-to-back items; it drops only for a gap or a drain
    task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] k,
                             input logic [PAY_W-1:0] p, input int gap);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data <= '{opcode: op, key: k, payload: p};
        i_in_valid <= 1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (op == OP_INSERT && key_pool.size() < 64) key_pool.push_back(k);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic set_size(input int s);
        drain();
        i_cfg_wdata <= SZ_W'(s);
        i_cfg_we <= 1;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: k = KEY_W'($urandom_range(0, 2000));
            1: if (key_pool.size() != 0) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            default: ;
        endcase
        return k;
    endfunction

    task automatic random_phase(input int count, input int burst);
        logic [1:0] op;
        int g;
        for (int i = 0; i < count; i++) begin
            op = $urandom_range(0, 9) < 4 ? OP_INSERT : ($urandom_range(0, 1) ? OP_SEARCH
                                                                             : OP_DELETE);
            if ($urandom_range(0, 49) == 0) op = OP_NONE;
            g = burst ? 0 : $urandom_range(0, 14);
            send_item(op, rand_key(), $urandom, g);
        end
    endtask

    initial begin
        int sizes[6] = '{3, 4, 7, 16, 1024, 0};
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = '0;
        i_in_valid = 0;
        i_in_data = '0;
        hold_out = 0;
        sink_run = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        sink_run = 1;

        // directed: extremes at reset size, then a fill-up of a tiny table
        send_item(OP_SEARCH, '1, '1, 0);
        send_item(OP_INSERT, '1, '1, 0);
        send_item(OP_INSERT, '0, '0, 2);
        send_item(OP_SEARCH, '1, 0, 0);
        send_item(OP_DELETE, '1, 0, 0);
        send_item(OP_SEARCH, '1, 0, 0);
        send_item(OP_DELETE, 48'h5, 0, 0);
        send_item(OP_NONE, '1, '1, 0);
        send_item(OP_SEARCH, '0, 0, 0);
        set_size(2);
        for (int i = 0; i < 4; i++) send_item(OP_INSERT, 48'd7, 32'hA5A5_0000 + i, 0);
        send_item(OP_DELETE, 48'd7, 0, 0);
        send_item(OP_SEARCH, 48'd7, 0, 0);
        send_item(OP_INSERT, 48'd9, 32'h1234, 0);
        send_item(OP_INSERT, 48'd10, 32'h5678, 0);
        set_size(2047);
        send_item(OP_SEARCH, 48'd7, 0, 0);
        send_item(OP_INSERT, 48'h8000_0000_0000, 32'h8000_0000, 0);
        send_item(OP_SEARCH, 48'h8000_0000_0000, 0, 0);

        // pressure: stalled receiver while the sender keeps going
        fork
            begin
                hold_out = 1;
                repeat (400) @(negedge i_clk);
                hold_out = 0;
            end
            random_phase(10, 1);
        join
        drain();

        for (int p = 0; p < 6; p++) begin
            set_size(p == 5 ? 1021 : sizes[p]);
            random_phase(p == 4 || p == 5 ? 300 : 150, 0);
        end
        random_phase(100, 1);

        drain();
        if (errors == 0) begin
            $display("PASS double_hash_table");
        end else begin
            $display("FAIL double_hash_table");
        end
        $finish;
    end

endmodule
